### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBRB_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fbrb assertion failed");

// Next-cycle implication, checked outside reset.
`define FBRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fbrb assertion failed");

`endif

### hdl/fbrb_pkg.sv
// Package with sizes, codes and shared types of the framed byte ring buffer.
package fbrb_pkg;

  localparam int RING_BYTES  = 1024;
  localparam int FRAME_SLOTS = 16;

  localparam int LEN_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int FRMO_W  = 5;
  localparam int RING_AW = $clog2(RING_BYTES);
  localparam int SLOT_AW = $clog2(FRAME_SLOTS);
  localparam int BYTES_W = $clog2(RING_BYTES + 1);
  localparam int FRM_W   = $clog2(FRAME_SLOTS + 1);
  localparam int CMP_W   = (BYTES_W > LEN_W) ? BYTES_W : LEN_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_SPACE = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  reader_space;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] read_byte;
    logic              frame_last;
    logic [LEN_W-1:0]  frame_length;
    logic [FRMO_W-1:0] frames_stored;
    logic [LEN_W-1:0]  bytes_stored;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } ring_wr_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    logic [LEN_W-1:0]   data;
  } lq_wr_t;

endpackage

### hdl/fbrb_ram.sv
// Simple dual-port synchronous RAM with registered read.
module fbrb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fbrb_core.sv
// Pointers, counters and frame bookkeeping that update around the two memories.
module fbrb_core import fbrb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [BYTE_W-1:0]  ring_rdata_i,
  input  logic [LEN_W-1:0]   lq_rdata_i,
  output logic [RING_AW-1:0] ring_raddr_o,
  output logic [SLOT_AW-1:0] lq_raddr_o,
  output ring_wr_t           ring_wr_o,
  output lq_wr_t             lq_wr_o,
  output result_t            result_o
);

  logic [RING_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [SLOT_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [FRM_W-1:0]   frames_q, frames_d;
  logic [LEN_W-1:0]   wr_rem_q, wr_rem_d, rd_rem_q, rd_rem_d;
  logic               drop_q, drop_d;

  logic [CMP_W-1:0]   free_ext, flen_ext;
  logic [LEN_W-1:0]   wr_after, rd_after;
  logic               store, go;
  status_e            status;
  logic [BYTE_W-1:0]  rbyte;
  logic               last;
  logic [LEN_W-1:0]   rlen;

  assign free_ext = CMP_W'(RING_BYTES) - CMP_W'(bytes_q);
  assign flen_ext = CMP_W'(item_i.frame_len);

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    head_d    = head_q;
    tail_d    = tail_q;
    bytes_d   = bytes_q;
    frames_d  = frames_q;
    wr_rem_d  = wr_rem_q;
    rd_rem_d  = rd_rem_q;
    drop_d    = drop_q;
    status    = ST_OK;
    rbyte     = '0;
    last      = 1'b0;
    rlen      = '0;
    store     = 1'b0;
    go        = 1'b1;
    wr_after  = wr_rem_q;
    rd_after  = rd_rem_q;
    ring_wr_o = '{we: 1'b0, addr: wp_q, data: item_i.data_byte};
    lq_wr_o   = '{we: 1'b0, addr: tail_q, data: item_i.frame_len};

    if (item_i.op == OP_WRITE) begin
      if (wr_rem_q == '0) begin
        if (item_i.frame_len == '0 || flen_ext > free_ext ||
            frames_q >= FRM_W'(FRAME_SLOTS)) begin
          status = ST_REFUSED;
          if (item_i.frame_len != '0) begin
            wr_rem_d = item_i.frame_len - LEN_W'(1);
            drop_d   = (item_i.frame_len != LEN_W'(1));
            last     = (item_i.frame_len == LEN_W'(1));
          end
        end else begin
          drop_d        = 1'b0;
          lq_wr_o.we    = step_i;
          store         = 1'b1;
          wr_after      = item_i.frame_len;
        end
      end else if (drop_q) begin
        status   = ST_REFUSED;
        wr_rem_d = wr_rem_q - LEN_W'(1);
        if (wr_rem_q == LEN_W'(1)) begin
          drop_d = 1'b0;
          last   = 1'b1;
        end
      end else begin
        store = 1'b1;
      end
      if (store) begin
        ring_wr_o.we = step_i;
        wp_d     = (wp_q == RING_AW'(RING_BYTES - 1)) ? '0 : wp_q + RING_AW'(1);
        bytes_d  = bytes_q + BYTES_W'(1);
        wr_rem_d = wr_after - LEN_W'(1);
        if (wr_after == LEN_W'(1)) begin
          last     = 1'b1;
          tail_d   = (tail_q == SLOT_AW'(FRAME_SLOTS - 1)) ? '0 : tail_q + SLOT_AW'(1);
          frames_d = frames_q + FRM_W'(1);
        end
      end
    end else begin
      if (rd_rem_q == '0) begin
        if (frames_q == '0) begin
          status = ST_EMPTY;
          go     = 1'b0;
        end else if (item_i.reader_space < lq_rdata_i) begin
          status = ST_NO_SPACE;
          go     = 1'b0;
        end else begin
          rd_after = lq_rdata_i;
        end
      end
      if (go && rd_after != '0) begin
        rlen     = lq_rdata_i;
        rbyte    = ring_rdata_i;
        rp_d     = (rp_q == RING_AW'(RING_BYTES - 1)) ? '0 : rp_q + RING_AW'(1);
        rd_rem_d = rd_after - LEN_W'(1);
        if (rd_after == LEN_W'(1)) begin
          last    = 1'b1;
          bytes_d = (CMP_W'(bytes_q) >= CMP_W'(lq_rdata_i)) ?
                    bytes_q - BYTES_W'(lq_rdata_i) : '0;
          head_d  = (head_q == SLOT_AW'(FRAME_SLOTS - 1)) ? '0 : head_q + SLOT_AW'(1);
          if (frames_q != '0) begin
            frames_d = frames_q - FRM_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      bytes_q  <= '0;
      frames_q <= '0;
      wr_rem_q <= '0;
      rd_rem_q <= '0;
      drop_q   <= 1'b0;
    end else if (step_i) begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      bytes_q  <= bytes_d;
      frames_q <= frames_d;
      wr_rem_q <= wr_rem_d;
      rd_rem_q <= rd_rem_d;
      drop_q   <= drop_d;
    end
  end

  assign ring_raddr_o = rp_q;
  assign lq_raddr_o   = head_q;

  assign result_o = '{status:        status,
                      read_byte:     rbyte,
                      frame_last:    last,
                      frame_length:  rlen,
                      frames_stored: FRMO_W'(frames_d),
                      bytes_stored:  LEN_W'(bytes_d)};

endmodule

### hdl/framed_byte_ring_buffer_unit.sv
// Top level of the framed byte ring buffer: handshake, memories and result register.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_ready_o | op, data_byte, frame_len, reader_space
//   out     | output    | out_valid_o / out_ready_i | status, read_byte, frame_last, ...
//
// Each word is handled in order: on acceptance the byte ring and the length queue are read
// at the current pointers; in S_EXEC the core updates state, writes back and loads the result.
// A new word is taken while the previous result still waits in the output register.
// If the output register is full and not taken, the update cycle waits for it.
// Reset clears all pointers and counters at once; the memories need no clearing.
module framed_byte_ring_buffer_unit import fbrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [LEN_W-1:0]  frame_len_i,
  input  logic [LEN_W-1:0]  reader_space_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              frame_last_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic [FRMO_W-1:0] frames_stored_o,
  output logic [LEN_W-1:0]  bytes_stored_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  item_t              item_q;
  result_t            res_q, res_c;
  logic               accept, step;
  logic [RING_AW-1:0] ring_raddr;
  logic [SLOT_AW-1:0] lq_raddr;
  logic [BYTE_W-1:0]  ring_rdata;
  logic [LEN_W-1:0]   lq_rdata;
  ring_wr_t           ring_wr;
  lq_wr_t             lq_wr;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (step) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{op: op_e'(op_i), data_byte: data_byte_i,
                  frame_len: frame_len_i, reader_space: reader_space_i};
    end
    if (step) begin
      res_q <= res_c;
    end
  end

  fbrb_ram #(
    .DEPTH(RING_BYTES),
    .WIDTH(BYTE_W)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_wr.we),
    .waddr_i(ring_wr.addr),
    .wdata_i(ring_wr.data),
    .re_i   (accept),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  fbrb_ram #(
    .DEPTH(FRAME_SLOTS),
    .WIDTH(LEN_W)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (lq_wr.we),
    .waddr_i(lq_wr.addr),
    .wdata_i(lq_wr.data),
    .re_i   (accept),
    .raddr_i(lq_raddr),
    .rdata_o(lq_rdata)
  );

  fbrb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .ring_rdata_i(ring_rdata),
    .lq_rdata_i  (lq_rdata),
    .ring_raddr_o(ring_raddr),
    .lq_raddr_o  (lq_raddr),
    .ring_wr_o   (ring_wr),
    .lq_wr_o     (lq_wr),
    .result_o    (res_c)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign read_byte_o     = res_q.read_byte;
  assign frame_last_o    = res_q.frame_last;
  assign frame_length_o  = res_q.frame_length;
  assign frames_stored_o = res_q.frames_stored;
  assign bytes_stored_o  = res_q.bytes_stored;

endmodule

### hdl/fbrb_checker.sv
// Port-level checker for the framed byte ring buffer, bound to the top level.
`include "assert_macros.svh"

module fbrb_checker import fbrb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              op_i,
  input logic [BYTE_W-1:0] data_byte_i,
  input logic [LEN_W-1:0]  frame_len_i,
  input logic [LEN_W-1:0]  reader_space_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [BYTE_W-1:0] read_byte_o,
  input logic              frame_last_o,
  input logic [LEN_W-1:0]  frame_length_o,
  input logic [FRMO_W-1:0] frames_stored_o,
  input logic [LEN_W-1:0]  bytes_stored_o
);

  `FBRB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(read_byte_o) && $stable(bytes_stored_o))
  `FBRB_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `FBRB_ASSERT_NOW(a_frames_max, clk_i, rst_ni, out_valid_o, 32'(frames_stored_o) <= 32'(FRAME_SLOTS))
  `FBRB_ASSERT_NOW(a_bytes_max, clk_i, rst_ni, out_valid_o, 32'(bytes_stored_o) <= 32'(RING_BYTES))
  `FBRB_ASSERT_NOW(a_refused_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, read_byte_o == '0 && frame_length_o == '0)

endmodule

bind framed_byte_ring_buffer_unit fbrb_checker u_fbrb_checker (.*);
